### hdl/swf_pkg.sv
// Shared types, constants and the microprogram for the servo sync-write packet framer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package swf_pkg;

    localparam int STEP_W      = 4;
    localparam int MAX_SERVOS  = 2;
    localparam int MAX_BYTES   = 2;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_LOOP     = 4'd8;
    localparam step_t STEP_CHECKSUM = 4'd11;

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] BCAST_ID   = 8'hFE;
    localparam logic [7:0] LEN_OFFSET = 8'd4;
    localparam logic [7:0] OPC_RESET  = 8'd131;

    // Byte source selected by the datapath multiplexer.
    typedef enum logic [3:0] {
        SRC_HDR,
        SRC_BCAST,
        SRC_LEN,
        SRC_OPC,
        SRC_ADDR,
        SRC_L,
        SRC_ID,
        SRC_B0,
        SRC_B1,
        SRC_CHK
    } src_t;

    // Sequencing condition of one microinstruction.
    typedef enum logic [2:0] {
        COND_WAIT_REQ,
        COND_NEXT,
        COND_GOTO,
        COND_SERVO_END_L1,
        COND_SERVO_END
    } cond_t;

    typedef struct packed {
        src_t  src;
        logic  emit;
        logic  sum_en;
        logic  last;
        cond_t cond;
        step_t target;
    } uword_t;

    // Datapath control issued by the sequencer for the current cycle.
    typedef struct packed {
        logic load;
        logic fire;
        src_t src;
        logic sum_en;
        logic last;
        logic servo_sel;
    } dp_ctrl_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic out_free;
        logic one_byte;
        logic two_servos;
    } dp_stat_t;

    // Saturate a 2-bit count: zero reads as one, and the count stops at the
    // configured maximum and at the two entries that the request carries.
    function automatic logic [1:0] clamp_count(input logic [1:0] v, input int maxp);
        logic [1:0] n;
        n = (v == 2'd0) ? 2'd1 : v;
        if (int'(n) > maxp) begin
            n = 2'(maxp);
        end
        if (n > 2'd2) begin
            n = 2'd2;
        end
        return n;
    endfunction

    // Microprogram: one control word per step.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = '{src: SRC_HDR, emit: 1'b0, sum_en: 1'b0, last: 1'b0,
              cond: COND_GOTO, target: STEP_IDLE};
        case (s)
            4'd0: begin
                w.cond = COND_WAIT_REQ;
            end
            4'd1: begin
                w.src = SRC_HDR;   w.emit = 1'b1; w.cond = COND_NEXT;
            end
            4'd2: begin
                w.src = SRC_HDR;   w.emit = 1'b1; w.cond = COND_NEXT;
            end
            4'd3: begin
                w.src = SRC_BCAST; w.emit = 1'b1; w.sum_en = 1'b1; w.cond = COND_NEXT;
            end
            4'd4: begin
                w.src = SRC_LEN;   w.emit = 1'b1; w.sum_en = 1'b1; w.cond = COND_NEXT;
            end
            4'd5: begin
                w.src = SRC_OPC;   w.emit = 1'b1; w.sum_en = 1'b1; w.cond = COND_NEXT;
            end
            4'd6: begin
                w.src = SRC_ADDR;  w.emit = 1'b1; w.sum_en = 1'b1; w.cond = COND_NEXT;
            end
            4'd7: begin
                w.src = SRC_L;     w.emit = 1'b1; w.sum_en = 1'b1; w.cond = COND_NEXT;
            end
            4'd8: begin
                w.src = SRC_ID;    w.emit = 1'b1; w.sum_en = 1'b1; w.cond = COND_NEXT;
            end
            4'd9: begin
                w.src = SRC_B0;    w.emit = 1'b1; w.sum_en = 1'b1;
                w.cond = COND_SERVO_END_L1; w.target = STEP_LOOP;
            end
            4'd10: begin
                w.src = SRC_B1;    w.emit = 1'b1; w.sum_en = 1'b1;
                w.cond = COND_SERVO_END; w.target = STEP_LOOP;
            end
            4'd11: begin
                w.src = SRC_CHK;   w.emit = 1'b1; w.last = 1'b1;
                w.cond = COND_GOTO; w.target = STEP_IDLE;
            end
            default: begin
                w.cond = COND_GOTO; w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hdl/servo_sync_write_packet_framer.sv
// Sync-write packet framer: a request with N servos of L bytes gives 7 + N*(L+1) + 1 bytes.
// Each step of the microprogram emits at most one byte, so the output runs at one byte per
// cycle while the output register is not held full. A request is taken only in the wait step,
// which the sequencer enters again once the checksum byte has been issued.
// aresetn is synchronous and active low; it idles the sequencer, empties the output register
// and restores the opcode register to 0x83. Depends on swf_pkg, swf_sequencer, swf_datapath.
`default_nettype none

module servo_sync_write_packet_framer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Request channel. The sequencer takes a request only in its wait step, so one
    // packet is framed at a time.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // From bit 0 up: start_address[7:0], servo_count[1:0], bytes_per_servo[1:0],
    // first_id[7:0], first_byte0[7:0], first_byte1[7:0], second_id[7:0],
    // second_byte0[7:0], second_byte1[7:0], then four zero bits.
    input  wire logic [63:0] s_tdata,

    // Byte stream toward the serial transmitter.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // From bit 0 up: tx_byte[7:0].
    output logic [7:0]       m_tdata,
    // last_byte: high on the checksum byte that closes the packet.
    output logic             m_tlast,

    // Opcode register write; it is always ready.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    swf_pkg::dp_ctrl_t ctrl;
    swf_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    // The sequencer walks the microprogram: header bytes, then a loop over the
    // servos in which the second data byte is skipped when L is one, then the
    // checksum. A step that emits a byte waits while the output register is full.
    swf_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // The datapath holds the request, forms each byte, keeps the running sum from
    // the broadcast ID onward and registers the outgoing byte.
    swf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_data  (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

### hdl/swf_sequencer.sv
// Microcode sequencer: step counter, servo loop counter and conditional jumps.
// Depends on swf_pkg for the microprogram and the control and status structs.
`default_nettype none

module swf_sequencer (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  swf_pkg::dp_stat_t     stat,
    output swf_pkg::dp_ctrl_t     ctrl
);

    swf_pkg::step_t  step_reg, step_next;
    logic            servo_reg, servo_next;
    swf_pkg::uword_t uw;
    logic            fire;
    logic            last_servo;

    assign uw         = swf_pkg::ucode(step_reg);
    assign req_ready  = (uw.cond == swf_pkg::COND_WAIT_REQ);
    assign fire       = uw.emit && stat.out_free;
    assign last_servo = stat.two_servos ? servo_reg : 1'b1;

    always_comb begin
        step_next  = step_reg;
        servo_next = servo_reg;
        case (uw.cond)
            swf_pkg::COND_WAIT_REQ: begin
                if (req_valid) begin
                    step_next  = step_reg + 1'b1;
                    servo_next = 1'b0;
                end
            end
            swf_pkg::COND_NEXT: begin
                if (fire) begin
                    step_next = step_reg + 1'b1;
                end
            end
            swf_pkg::COND_GOTO: begin
                if (fire || !uw.emit) begin
                    step_next = uw.target;
                end
            end
            swf_pkg::COND_SERVO_END_L1: begin
                if (fire) begin
                    if (!stat.one_byte) begin
                        step_next = step_reg + 1'b1;
                    end else if (last_servo) begin
                        step_next = swf_pkg::STEP_CHECKSUM;
                    end else begin
                        step_next  = uw.target;
                        servo_next = servo_reg + 1'b1;
                    end
                end
            end
            swf_pkg::COND_SERVO_END: begin
                if (fire) begin
                    if (last_servo) begin
                        step_next = swf_pkg::STEP_CHECKSUM;
                    end else begin
                        step_next  = uw.target;
                        servo_next = servo_reg + 1'b1;
                    end
                end
            end
            default: begin
                step_next = swf_pkg::STEP_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl.load      = req_ready && req_valid;
        ctrl.fire      = fire;
        ctrl.src       = uw.src;
        ctrl.sum_en    = uw.sum_en;
        ctrl.last      = uw.last;
        ctrl.servo_sel = servo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= swf_pkg::STEP_IDLE;
            servo_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            servo_reg <= servo_next;
        end
    end

endmodule

`default_nettype wire

### hdl/swf_datapath.sv
// Datapath: held request, opcode register, byte multiplexer, checksum and output register.
// Depends on swf_pkg for the control and status structs and the packet constants.
`default_nettype none

module swf_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [63:0]   req_data,
    input  wire logic          cfg_valid,
    input  wire logic [7:0]    cfg_data,
    input  swf_pkg::dp_ctrl_t  ctrl,
    output swf_pkg::dp_stat_t  stat,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    logic [7:0] opc_reg;
    logic [7:0] addr_reg;
    logic       two_servos_reg;
    logic       two_bytes_reg;
    logic [7:0] id_reg [2];
    logic [7:0] b0_reg [2];
    logic [7:0] b1_reg [2];
    logic [7:0] sum_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_valid_reg, out_valid_next;

    logic [1:0] n_clamped, l_clamped;
    logic [7:0] n_val, l_val, length;
    logic [7:0] byte_sel;

    assign n_clamped = swf_pkg::clamp_count(req_data[9:8], swf_pkg::MAX_SERVOS);
    assign l_clamped = swf_pkg::clamp_count(req_data[11:10], swf_pkg::MAX_BYTES);

    assign n_val  = two_servos_reg ? 8'd2 : 8'd1;
    assign l_val  = two_bytes_reg ? 8'd2 : 8'd1;
    assign length = 8'((l_val + 8'd1) * n_val + swf_pkg::LEN_OFFSET);

    always_comb begin
        case (ctrl.src)
            swf_pkg::SRC_HDR:   byte_sel = swf_pkg::HDR_BYTE;
            swf_pkg::SRC_BCAST: byte_sel = swf_pkg::BCAST_ID;
            swf_pkg::SRC_LEN:   byte_sel = length;
            swf_pkg::SRC_OPC:   byte_sel = opc_reg;
            swf_pkg::SRC_ADDR:  byte_sel = addr_reg;
            swf_pkg::SRC_L:     byte_sel = l_val;
            swf_pkg::SRC_ID:    byte_sel = id_reg[ctrl.servo_sel];
            swf_pkg::SRC_B0:    byte_sel = b0_reg[ctrl.servo_sel];
            swf_pkg::SRC_B1:    byte_sel = b1_reg[ctrl.servo_sel];
            swf_pkg::SRC_CHK:   byte_sel = ~sum_reg;
            default:            byte_sel = swf_pkg::HDR_BYTE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.fire) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.one_byte   = !two_bytes_reg;
    assign stat.two_servos = two_servos_reg;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opc_reg       <= swf_pkg::OPC_RESET;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                opc_reg <= cfg_data;
            end
            if (ctrl.load) begin
                sum_reg <= 8'd0;
            end else if (ctrl.fire && ctrl.sum_en) begin
                sum_reg <= sum_reg + byte_sel;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            addr_reg       <= req_data[7:0];
            two_servos_reg <= (n_clamped == 2'd2);
            two_bytes_reg  <= (l_clamped == 2'd2);
            id_reg[0]      <= req_data[19:12];
            b0_reg[0]      <= req_data[27:20];
            b1_reg[0]      <= req_data[35:28];
            id_reg[1]      <= req_data[43:36];
            b0_reg[1]      <= req_data[51:44];
            b1_reg[1]      <= req_data[59:52];
        end
        if (ctrl.fire) begin
            out_byte_reg <= byte_sel;
            out_last_reg <= ctrl.last;
        end
    end

endmodule

`default_nettype wire

### tb/tb_servo_sync_write_packet_framer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the servo sync-write packet framer: drives requests, frames the
// expected byte stream in a local model and compares every byte and its last flag.
// Depends on swf_pkg and servo_sync_write_packet_framer.

module tb_servo_sync_write_packet_framer;

    // A watchdog ends the run after this many cycles without any handshake.
    localparam int IDLE_LIMIT    = 2000;
    localparam int N_DIRECTED    = 17;
    localparam int N_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 63;
    // Cycles allowed for the framer to return to its wait step after the last byte.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;

    // One sync-write request, fields in the order they sit in s_tdata from bit 0 up.
    typedef struct packed {
        logic [7:0] start_address;
        logic [1:0] servo_count;
        logic [1:0] bytes_per_servo;
        logic [7:0] first_id;
        logic [7:0] first_byte0;
        logic [7:0] first_byte1;
        logic [7:0] second_id;
        logic [7:0] second_byte0;
        logic [7:0] second_byte1;
    } sync_req_t;

    // A directed row. Where known_frame is set, the length byte and the checksum are
    // typed in by hand and override the model's values for that packet.
    typedef struct packed {
        logic       known_frame;
        logic [7:0] length_byte;
        logic [7:0] checksum_byte;
        sync_req_t  req;
    } directed_row_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } tx_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    // Model state: the opcode register as the framer should currently hold it.
    logic [7:0]  opcode_now = swf_pkg::OPC_RESET;
    tx_byte_t    pending_bytes[$];
    tx_byte_t    head_byte;
    // Queue position of the first byte of the most recently framed packet.
    int          frame_start = 0;

    directed_row_t directed_rows [N_DIRECTED];
    logic [7:0]    phase_opcodes [N_PHASES];

    int          error_count    = 0;
    int          requests_sent  = 0;
    int          bytes_checked  = 0;
    int          packets_closed = 0;
    int          opcode_writes  = 0;
    int          burst_left     = 0;
    int          idle_cycles    = 0;
    logic [31:0] cycle_count    = '0;

    servo_sync_write_packet_framer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t ns, packet %0d: %s, got %02h, expected %02h",
                 $time, packets_closed, what, got, want);
        error_count++;
    endtask

    // Saturating decode of a two-bit count: zero reads as one, and the value is limited
    // both by the framer's maximum and by the two entries the request can carry.
    function automatic int decode_count(input logic [1:0] raw, input int max_allowed);
        int n;
        n = (raw == 2'd0) ? 1 : int'(raw);
        if (n > max_allowed) begin
            n = max_allowed;
        end
        if (n > 2) begin
            n = 2;
        end
        return n;
    endfunction

    // Appends the full broadcast packet that a request should produce to pending_bytes.
    function automatic void frame_request(input sync_req_t r);
        int         servos;
        int         width;
        logic [7:0] sum;
        logic [7:0] body [$];
        logic [7:0] ids [2];
        logic [7:0] data [2][2];
        frame_start = pending_bytes.size();
        servos = decode_count(r.servo_count, swf_pkg::MAX_SERVOS);
        width  = decode_count(r.bytes_per_servo, swf_pkg::MAX_BYTES);
        ids[0]     = r.first_id;
        ids[1]     = r.second_id;
        data[0][0] = r.first_byte0;
        data[0][1] = r.first_byte1;
        data[1][0] = r.second_byte0;
        data[1][1] = r.second_byte1;

        // Everything from the broadcast ID up to the last data byte is summed.
        body.push_back(swf_pkg::BCAST_ID);
        body.push_back(8'((width + 1) * servos) + swf_pkg::LEN_OFFSET);
        body.push_back(opcode_now);
        body.push_back(r.start_address);
        body.push_back(8'(width));
        for (int s = 0; s < servos; s++) begin
            body.push_back(ids[s]);
            for (int j = 0; j < width; j++) begin
                body.push_back(data[s][j]);
            end
        end

        sum = '0;
        pending_bytes.push_back('{value: swf_pkg::HDR_BYTE, last: 1'b0});
        pending_bytes.push_back('{value: swf_pkg::HDR_BYTE, last: 1'b0});
        foreach (body[k]) begin
            sum += body[k];
            pending_bytes.push_back('{value: body[k], last: 1'b0});
        end
        pending_bytes.push_back('{value: ~sum, last: 1'b1});
    endfunction

    // Data bytes lean toward the extremes now and then.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Most requests carry a legal count and length; the rest exercise the saturating decode.
    function automatic logic [1:0] pick_count();
        if ($urandom_range(0, 99) < 85) begin
            return 2'($urandom_range(1, 2));
        end
        return ($urandom_range(0, 1) == 0) ? 2'd0 : 2'd3;
    endfunction

    function automatic sync_req_t random_request();
        sync_req_t r;
        r.start_address   = pick_byte();
        r.servo_count     = pick_count();
        r.bytes_per_servo = pick_count();
        r.first_id        = pick_byte();
        r.first_byte0     = pick_byte();
        r.first_byte1     = pick_byte();
        r.second_id       = pick_byte();
        r.second_byte0    = pick_byte();
        r.second_byte1    = pick_byte();
        return r;
    endfunction

    // The sender works in bursts. Between bursts the valid drops for a random pause;
    // inside a burst the next request is presented as soon as its predecessor was taken.
    task automatic pace_sender();
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
        end
        burst_left--;
    endtask

    // Presents one request and holds it until the framer takes it, then frames its packet.
    task automatic push_request(input sync_req_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, r.second_byte1, r.second_byte0, r.second_id, r.first_byte1,
                     r.first_byte0, r.first_id, r.bytes_per_servo, r.servo_count,
                     r.start_address};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        frame_request(r);
    endtask

    // Waits until every expected byte has come back, lets the framer settle, then
    // writes a new opcode while nothing is in flight.
    task automatic drain_and_write_opcode(input logic [7:0] opcode);
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= opcode;
        do @(posedge aclk); while (!cfg_ready);
        opcode_now = opcode;
        opcode_writes++;
        cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Result side: every byte taken is compared with the oldest expected byte. The ready
    // follows a pattern of its own, chosen by bits 9:8 of the cycle counter: always ready, mostly
    // ready, mostly stalled, and a fixed one-in-four stall.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                report_mismatch("byte with no request pending", m_tdata, 0);
            end else begin
                head_byte = pending_bytes.pop_front();
                if (m_tdata !== head_byte.value) begin
                    report_mismatch("tx_byte", m_tdata, head_byte.value);
                end
                if (m_tlast !== head_byte.last) begin
                    report_mismatch("last_byte", m_tlast, head_byte.last);
                end
                if (head_byte.last) begin
                    packets_closed++;
                end
            end
        end
        case (cycle_count[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 9) < 3);
            default: m_tready <= (cycle_count[1:0] != 2'd3);
        endcase
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d bytes still expected",
                     IDLE_LIMIT, pending_bytes.size());
            $display("tb_servo_sync_write_packet_framer: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        // Directed part, run with the opcode register at its reset value 0x83. The typed
        // length and checksum come straight from summing the packet by hand.
        directed_rows = '{
            // known  len    chk     addr   N     L     id1    d0     d1     id2    d0     d1
            '{1'b1, 8'h06, 8'h77, '{8'h00, 2'd1, 2'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            // Count and length of zero both read as one.
            '{1'b1, 8'h06, 8'h77, '{8'h00, 2'd0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            '{1'b1, 8'h08, 8'h75, '{8'h00, 2'd2, 2'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            '{1'b1, 8'h07, 8'h75, '{8'h00, 2'd1, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            '{1'b1, 8'h0A, 8'h72, '{8'h00, 2'd2, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            // All ones: count and length of three saturate to two, the sum wraps.
            '{1'b1, 8'h0A, 8'h79, '{8'hFF, 2'd3, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
            '{1'b1, 8'h0A, 8'h79, '{8'hFF, 2'd2, 2'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
            // Sums chosen so the checksum comes out as zero and as all ones.
            '{1'b1, 8'h06, 8'h00, '{8'h77, 2'd1, 2'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            '{1'b1, 8'h06, 8'hFF, '{8'h78, 2'd1, 2'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            '{1'b0, 8'h00, 8'h00, '{8'h12, 2'd3, 2'd0, 8'h01, 8'h23, 8'h45, 8'h02, 8'h67, 8'h89}},
            '{1'b0, 8'h00, 8'h00, '{8'h34, 2'd0, 2'd3, 8'h03, 8'hAB, 8'hCD, 8'h04, 8'hEF, 8'h10}},
            '{1'b0, 8'h00, 8'h00, '{8'h1E, 2'd2, 2'd2, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66}},
            // Second servo fields and the unused high byte must not leak into the packet.
            '{1'b0, 8'h00, 8'h00, '{8'hFF, 2'd1, 2'd2, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}},
            '{1'b0, 8'h00, 8'h00, '{8'h20, 2'd2, 2'd1, 8'h05, 8'h9C, 8'hFF, 8'h06, 8'h3A, 8'hFF}},
            '{1'b0, 8'h00, 8'h00, '{8'hAA, 2'd2, 2'd2, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}},
            '{1'b0, 8'h00, 8'h00, '{8'h55, 2'd1, 2'd2, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}},
            '{1'b0, 8'h00, 8'h00, '{8'h1E, 2'd1, 2'd1, 8'hFE, 8'h01, 8'h80, 8'h7F, 8'hC0, 8'h3F}}
        };
        // Opcode settings for the random phases: both extremes, two random values and a
        // return to the reset value.
        phase_opcodes = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), swf_pkg::OPC_RESET};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            pace_sender();
            push_request(directed_rows[i].req);
            // For hand-checked rows the typed values stand in for the model's own.
            if (directed_rows[i].known_frame) begin
                pending_bytes[frame_start + 3].value = directed_rows[i].length_byte;
                pending_bytes[pending_bytes.size() - 1].value = directed_rows[i].checksum_byte;
            end
        end

        foreach (phase_opcodes[p]) begin
            drain_and_write_opcode(phase_opcodes[p]);
            repeat (ITEMS_PER_PHASE) begin
                pace_sender();
                push_request(random_request());
            end
        end

        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests (%0d directed) and %0d packet bytes in %0d packets,",
                 requests_sent, N_DIRECTED, bytes_checked, packets_closed);
        $display("across %0d opcode writes including 0x00, 0xFF and the reset value; %0d errors.",
                 opcode_writes, error_count);
        if (error_count == 0) begin
            $display("tb_servo_sync_write_packet_framer: PASS");
        end else begin
            $display("tb_servo_sync_write_packet_framer: FAIL");
        end
        $finish;
    end

endmodule

### files.f
hdl/swf_pkg.sv
hdl/swf_sequencer.sv
hdl/swf_datapath.sv
hdl/servo_sync_write_packet_framer.sv
tb/tb_servo_sync_write_packet_framer.sv
